/* rtl/core/bcoef_pkg.sv */
// ----------------------------------------------------------------------------
// bcoef_pkg
// Shared widths, controller states and command/status bundles for the
// binomial coefficient block.
// ----------------------------------------------------------------------------
package bcoef_pkg;

  localparam int N_W    = 6;   // n field
  localparam int K_W    = 7;   // k field, two's complement
  localparam int COEF_W = 59;  // result field
  localparam int ACC_W  = 64;  // running product before the exact divide
  localparam int DCNT_W = 6;   // bit counter of the serial divider

  typedef logic [N_W-1:0]    n_t;
  typedef logic [K_W-1:0]    k_t;
  typedef logic [COEF_W-1:0] coef_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_CHECK,
    ST_MUL,
    ST_DIV,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;      // capture the request operands
    logic setup;     // range check, fold k, seed the product
    logic mul;       // product times next factor
    logic div_step;  // one restoring-divide bit
    logic out_load;  // move the product into the result register
  } cmd_t;

  typedef struct packed {
    logic steps_done;
    logic div_last;
  } status_t;

endpackage

/* rtl/core/bcoef_in_if.sv */
// ----------------------------------------------------------------------------
// bcoef_in_if
// Request channel: a pair (n, k) with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bcoef_in_if;
  logic          valid;
  logic          ready;
  bcoef_pkg::n_t n;
  bcoef_pkg::k_t k;

  modport source (output valid, output n, output k, input ready);
  modport sink   (input valid, input n, input k, output ready);
endinterface

/* rtl/core/bcoef_out_if.sv */
// ----------------------------------------------------------------------------
// bcoef_out_if
// Result channel: the coefficient with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bcoef_out_if;
  logic             valid;
  logic             ready;
  bcoef_pkg::coef_t coefficient;

  modport source (output valid, output coefficient, input ready);
  modport sink   (input valid, input coefficient, output ready);
endinterface

/* rtl/core/bcoef_ctrl.sv */
// ----------------------------------------------------------------------------
// bcoef_ctrl
// Sequencer: walks setup, then multiply/divide steps, then hands the
// result to the output register.
// ----------------------------------------------------------------------------
module bcoef_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output bcoef_pkg::cmd_t    cmd,
  input  bcoef_pkg::status_t status
);
  import bcoef_pkg::*;

  state_t state, state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        state_next = status.steps_done ? ST_FINISH : ST_MUL;
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) state_next = ST_CHECK;
      end
      ST_FINISH: begin
        // wait for the result register to free up
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
    out_valid_next = cmd.out_load | (out_valid & ~out_ready);
  end

endmodule

/* rtl/core/bcoef_dp.sv */
// ----------------------------------------------------------------------------
// bcoef_dp
// Datapath: operand registers, step counter, narrow multiplier and a
// one-bit-per-cycle restoring divider sharing the product register.
// ----------------------------------------------------------------------------
module bcoef_dp #(
  parameter int MAX_N  = 62,
  parameter int STEP_W = 6
) (
  input  logic                clk,
  input  bcoef_pkg::cmd_t     cmd,
  output bcoef_pkg::status_t  status,
  input  bcoef_pkg::n_t       n,
  input  bcoef_pkg::k_t       k,
  output bcoef_pkg::coef_t    coefficient
);
  import bcoef_pkg::*;

  n_t                n_reg;
  k_t                k_reg;
  logic [STEP_W-1:0] kmin;
  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] rem;
  logic [DCNT_W-1:0] dcnt;
  logic [ACC_W-1:0]  acc;

  logic              valid_pair;
  n_t                k_low, n_minus_k, k_fold, factor;
  logic [ACC_W:0]    product;
  logic [STEP_W:0]   rem_sh, rem_sub;
  logic              rem_ge;

  always_comb begin
    k_low      = k_reg[N_W-1:0];
    n_minus_k  = n_reg - k_low;
    valid_pair = !k_reg[K_W-1] && (k_low <= n_reg) && (n_reg <= N_W'(MAX_N));
    k_fold     = (n_minus_k < k_low) ? n_minus_k : k_low;
    factor     = n_reg - N_W'(kmin) + N_W'(step);
    product    = {{(N_W){1'b0}}, acc[COEF_W-1:0]} * {{(COEF_W){1'b0}}, factor};
    rem_sh     = {rem, acc[ACC_W-1]};
    rem_sub    = rem_sh - {1'b0, step};
    rem_ge     = rem_sh >= {1'b0, step};
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n_reg <= n;
      k_reg <= k;
    end
    if (cmd.setup) begin
      // invalid pairs run zero steps on a zero product
      kmin <= valid_pair ? STEP_W'(k_fold) : '0;
      acc  <= valid_pair ? ACC_W'(1) : '0;
      step <= STEP_W'(1);
    end
    if (cmd.mul) begin
      acc  <= product[ACC_W-1:0];
      rem  <= '0;
      dcnt <= '0;
    end
    if (cmd.div_step) begin
      acc  <= {acc[ACC_W-2:0], rem_ge};
      rem  <= rem_ge ? rem_sub[STEP_W-1:0] : rem_sh[STEP_W-1:0];
      dcnt <= dcnt + DCNT_W'(1);
      if (dcnt == DCNT_W'(ACC_W - 1)) step <= step + STEP_W'(1);
    end
    if (cmd.out_load) coefficient <= acc[COEF_W-1:0];
  end

  assign status.steps_done = step > kmin;
  assign status.div_last   = dcnt == DCNT_W'(ACC_W - 1);

endmodule

/* rtl/core/binomial_coefficient.sv */
// ----------------------------------------------------------------------------
// binomial_coefficient
// Exact C(n, k) by the multiplicative rule: k' = min(k, n-k) steps, each a
// multiply by (n-k'+i) followed by an exact serial divide by i.
// ----------------------------------------------------------------------------
//  channel    dir  payload                 handshake
//  operands   in   n[5:0], k[6:0] signed   valid/ready
//  result     out  coefficient[58:0]       valid/ready
//
// One request at a time; k' = min(k, n-k) steps per request. Each step is
// a multiply, the serial one-bit restoring divide and a check.
// Invalid pairs and k' = 0 skip the steps. Reset is synchronous and
// clears only control state. A result held in the output register does not
// block the next request; a finished request waits only if that register is
// still full.
// ----------------------------------------------------------------------------
module binomial_coefficient #(
  parameter int MAX_N = 62
) (
  input logic         clk,
  input logic         rst,
  bcoef_in_if.sink    operands,
  bcoef_out_if.source result
);
  import bcoef_pkg::*;

  localparam int STEP_W = $clog2(MAX_N / 2 + 2);

  cmd_t    cmd;
  status_t status;

  bcoef_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (operands.valid),
    .in_ready  (operands.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .cmd       (cmd),
    .status    (status)
  );

  bcoef_dp #(
    .MAX_N  (MAX_N),
    .STEP_W (STEP_W)
  ) u_dp (
    .clk         (clk),
    .cmd         (cmd),
    .status      (status),
    .n           (operands.n),
    .k           (operands.k),
    .coefficient (result.coefficient)
  );

endmodule

/* dv/tb_binomial_coefficient.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_binomial_coefficient
// Drives (n, k) requests through the operand channel and checks every
// coefficient against an exact multiplicative predictor. Covers extreme and
// invalid pairs, then random requests weighted towards cheap folds, under
// phases of sender idling and receiver back-pressure.
// ----------------------------------------------------------------------------
module tb_binomial_coefficient;
  import bcoef_pkg::*;

  localparam int MAX_N        = 62;
  localparam int NUM_RANDOM   = 250;
  localparam int PHASE_LEN    = 30;     // requests per idling phase
  localparam int STALL_LIMIT  = 20000;  // quiet cycles before giving up
  localparam int DRAIN_CYCLES = 50;

  typedef struct packed {
    n_t n;
    k_t k;
  } pair_t;

  logic clk = 1'b0;
  logic rst;

  bcoef_in_if  operands ();
  bcoef_out_if result ();

  binomial_coefficient #(
    .MAX_N(MAX_N)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .operands (operands),
    .result   (result)
  );

  always #5 clk = ~clk;

  pair_t pair_q[$];        // requests not yet offered
  coef_t coef_pending[$];  // coefficients owed by the block
  int    accepted     = 0;
  int    received     = 0;
  int    err_count    = 0;
  int    quiet_cycles = 0;
  logic  req_taken    = 1'b0;

  wire [1:0] idle_phase = 2'((accepted / PHASE_LEN) % 4);

  // Exact C(n, k); the product before each divide stays below 2^64.
  function automatic coef_t choose_count(input n_t n_in, input k_t k_in);
    logic [63:0] prod;
    int          nn;
    int          kk;
    nn   = int'(n_in);
    kk   = int'($signed(k_in));
    prod = 64'd1;
    if (kk < 0 || kk > nn || nn > MAX_N) return '0;
    if (nn - kk < kk) kk = nn - kk;
    for (int i = 1; i <= kk; i++) begin
      prod = prod * 64'(nn - kk + i);
      prod = prod / 64'(i);
    end
    return coef_t'(prod);
  endfunction

  function automatic bit roll(input int pct);
    return $urandom_range(99, 0) < pct;
  endfunction

  task automatic add_pair(input int n_val, input int k_val);
    pair_t p;
    p.n = n_t'(n_val);
    p.k = k_t'(k_val);
    pair_q.push_back(p);
  endtask

  // request driver
  always @(negedge clk) begin
    pair_t nxt;
    if (!rst && (!operands.valid || req_taken)) begin
      if (pair_q.size() != 0 &&
          !roll(idle_phase == 2'd1 ? 83 : idle_phase == 2'd3 ? 29 : 0)) begin
        nxt = pair_q.pop_front();
        operands.valid <= 1'b1;
        operands.n     <= nxt.n;
        operands.k     <= nxt.k;
      end else begin
        operands.valid <= 1'b0;
      end
    end
  end

  // result back-pressure
  always @(negedge clk) begin
    result.ready <= !roll(idle_phase == 2'd2 ? 83 : idle_phase == 2'd3 ? 29 : 0);
  end

  // monitor, scoreboard and watchdog
  always @(posedge clk) begin
    coef_t want;
    req_taken <= operands.valid && operands.ready;
    if (!rst) begin
      if (operands.valid && operands.ready) begin
        coef_pending.push_back(choose_count(operands.n, operands.k));
        accepted <= accepted + 1;
      end
      if (result.valid && result.ready) begin
        received <= received + 1;
        if (coef_pending.size() == 0) begin
          $error("coefficient: unexpected result %0d", result.coefficient);
          err_count++;
        end else begin
          want = coef_pending.pop_front();
          if (result.coefficient !== want) begin
            $error("coefficient: expected %0d, actual %0d", want, result.coefficient);
            err_count++;
          end
        end
      end
      if ((operands.valid && operands.ready) || (result.valid && result.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("** binomial_coefficient: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    int nn;
    int kk;
    int sel;
    int j;
    int total_items;
    operands.valid = 1'b0;
    operands.n     = '0;
    operands.k     = '0;
    result.ready   = 1'b0;
    rst            = 1'b1;

    // directed: trivial, central, invalid and out-of-range pairs
    add_pair(0, 0);
    add_pair(62, 31);
    add_pair(62, 30);
    add_pair(62, 32);
    add_pair(62, 0);
    add_pair(62, 62);
    add_pair(62, 63);
    add_pair(62, 1);
    add_pair(62, 61);
    add_pair(63, 31);
    add_pair(63, 0);
    add_pair(63, 63);
    add_pair(5, -1);
    add_pair(5, -64);
    add_pair(0, 63);
    add_pair(0, 1);
    add_pair(1, 1);
    add_pair(7, 8);
    add_pair(10, 3);
    add_pair(10, 7);
    add_pair(33, 16);
    add_pair(42, 21);
    add_pair(62, -1);

    // random: cheap folds near either end for 45%, the rest wider or raw k
    for (int i = 0; i < NUM_RANDOM; i++) begin
      nn  = $urandom_range(63, 0);
      sel = $urandom_range(99, 0);
      if (sel < 45) begin
        j  = $urandom_range(4, 0);
        kk = $urandom_range(1, 0) ? j : nn - j;
      end else if (sel < 65) begin
        kk = $urandom_range(nn, 0);
      end else if (sel < 75) begin
        kk = $urandom_range(63, 0);
      end else begin
        kk = $urandom_range(127, 0);  // raw bits, negative half included
      end
      add_pair(nn, kk);
    end
    total_items = pair_q.size();

    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // every request must come back; the watchdog covers a lost one
    while (received < total_items)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (coef_pending.size() != 0) begin
      $error("coefficient: %0d results never arrived", coef_pending.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("** binomial_coefficient: PASSED **");
    end else begin
      $display("** binomial_coefficient: FAILED **");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/bcoef_pkg.sv
rtl/core/bcoef_in_if.sv
rtl/core/bcoef_out_if.sv
rtl/core/bcoef_ctrl.sv
rtl/core/bcoef_dp.sv
rtl/core/binomial_coefficient.sv
dv/tb_binomial_coefficient.sv
